>>> hw/rtl/godf_pkg.sv
// shared types, command codes and step tables for the octile distance field
package godf_pkg;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BUILD = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic REPLY_BUILD = 1'b0;
	localparam logic REPLY_READ  = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam int CFG_BITS = 7;
	localparam logic CFG_GRID_WIDTH  = 1'b0;
	localparam logic CFG_GRID_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [5:0] x_coord;
		logic [5:0] y_coord;
		logic       blocked;
	} req_t;

	typedef struct packed {
		logic        reply_kind;
		logic [15:0] path_cost;
		logic        reached;
		logic        status;
	} rsp_t;

	// x offset of neighbor d
	function automatic logic signed [1:0] step_dx(input logic [2:0] d);
		logic signed [1:0] r;
		case (d)
			3'd0, 3'd4, 3'd5: r = -2'sd1;
			3'd1, 3'd6, 3'd7: r = 2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	// y offset of neighbor d
	function automatic logic signed [1:0] step_dy(input logic [2:0] d);
		logic signed [1:0] r;
		case (d)
			3'd2, 3'd4, 3'd6: r = -2'sd1;
			3'd3, 3'd5, 3'd7: r = 2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	// straight steps cost 10, diagonal steps 14
	function automatic logic [3:0] step_len(input logic [2:0] d);
		return d[2] ? 4'd14 : 4'd10;
	endfunction

endpackage

>>> hw/rtl/grid_octile_distance_field.sv
// top level of the octile distance field: obstacle grid, spfa relaxation, cost reads
// Holds an obstacle grid and a cost field of MAX_WIDTH x MAX_HEIGHT cells, each at address
// y * MAX_WIDTH + x. A load transaction writes one obstacle bit and gives no reply. A read
// transaction in the grid returns the cost and reached flag of one cell and stalls the
// request side while the node ram is read, then the reply register is loaded. A build
// transaction with its goal in the grid first sweeps the node ram back to unreached, one
// cell per cycle, then seeds the goal and runs a queue-based relaxation: each dequeued cell
// passes through the pop read, pop wait and base states, then each neighbor is either
// skipped or examined (read, then read-modify-write of the node ram).
// After reset the block runs the same sweep, clearing obstacles too, before the first
// transaction is taken. Configuration writes are taken at any time but must only happen
// while the block is idle.
module grid_octile_distance_field
	import godf_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int COST_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                req_valid,
	output logic                req_stall,
	input  req_t                req,
	// reply channel
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_t                rsp,
	// configuration write port
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int QW    = XW + YW;
	localparam int NW    = COST_BITS + 2;
	// common width for coordinate compares, covers 11-bit neighbor coordinates
	localparam int CW    = 12;

	localparam logic [CW-1:0] MAX_W_C = CW'(MAX_WIDTH);
	localparam logic [CW-1:0] MAX_H_C = CW'(MAX_HEIGHT);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [COST_BITS-1:0] COST_MAX = '1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED,
		ST_POP_RD,
		ST_POP_WAIT,
		ST_BASE,
		ST_NB_RD,
		ST_NB_WR,
		ST_DONE
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
		return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
	endfunction

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == LAST_CELL) ? '0 : p + 1'b1;
	endfunction

	// saturate a stored cost to the 16-bit reply field
	function automatic logic [15:0] cost_out(input logic [COST_BITS-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	state_t st_q;
	logic [AW-1:0]  clr_q;
	logic           clr_obs_q;
	logic [AW-1:0]  head_q, tail_q;
	logic [AW:0]    cnt_q;
	logic [XW-1:0]  ux_q, gx_q;
	logic [YW-1:0]  uy_q, gy_q;
	logic [AW-1:0]  uaddr_q, naddr_q;
	logic [COST_BITS-1:0] base_q;
	logic [2:0]     d_q;
	logic [3:0]     sopen_q;
	logic           rd_s1;
	logic           rsp_valid_q;
	rsp_t           rsp_q;
	logic [CFG_BITS-1:0] gw_q, gh_q;

	// ram ports
	logic          obs_we, obs_rdata;
	logic [AW-1:0] obs_waddr, obs_raddr;
	logic          obs_wdata;
	logic          node_we;
	logic [AW-1:0] node_waddr, node_raddr;
	logic [NW-1:0] node_wdata, node_rdata;
	logic          q_we;
	logic [AW-1:0] q_waddr, q_raddr;
	logic [QW-1:0] q_wdata, q_rdata;

	// effective grid size, capped at the stored array
	logic [CW-1:0] eff_w, eff_h;
	assign eff_w = (CW'(gw_q) > MAX_W_C) ? MAX_W_C : CW'(gw_q);
	assign eff_h = (CW'(gh_q) > MAX_H_C) ? MAX_H_C : CW'(gh_q);

	// request side
	logic req_acc, req_in_grid, req_in_array;
	logic [AW-1:0] req_addr;
	assign req_stall    = (st_q != ST_IDLE) || rd_s1 || (rsp_valid_q && rsp_stall);
	assign req_acc      = req_valid && !req_stall;
	assign req_in_grid  = (CW'(req.x_coord) < eff_w) && (CW'(req.y_coord) < eff_h);
	assign req_in_array = (CW'(req.x_coord) < MAX_W_C) && (CW'(req.y_coord) < MAX_H_C);
	assign req_addr     = cell_addr(YW'(req.y_coord), XW'(req.x_coord));

	// neighbor of the current cell in direction d_q; -1 wraps to all ones, which is outside
	logic [XW:0] nx;
	logic [YW:0] ny;
	logic        n_in_grid, n_eligible;
	logic [AW-1:0] n_addr;
	logic signed [1:0] dx, dy;
	assign dx = step_dx(d_q);
	assign dy = step_dy(d_q);
	assign nx = {1'b0, ux_q} + {{XW{dx[1]}}, dx[0]};
	assign ny = {1'b0, uy_q} + {{YW{dy[1]}}, dy[0]};
	assign n_in_grid = (CW'(nx) < eff_w) && (CW'(ny) < eff_h);
	assign n_addr = cell_addr(ny[YW-1:0], nx[XW-1:0]);
	// a diagonal needs both adjacent straight cells open
	assign n_eligible = n_in_grid &&
		(!d_q[2] || (sopen_q[{1'b0, d_q[1]}] && sopen_q[{1'b1, d_q[0]}]));

	// relaxation of the examined neighbor
	logic          n_inq, n_reach, n_open, n_improve;
	logic [COST_BITS-1:0] n_cost, new_cost;
	logic [COST_BITS:0]   sum;
	assign n_inq     = node_rdata[NW-1];
	assign n_reach   = node_rdata[NW-2];
	assign n_cost    = node_rdata[COST_BITS-1:0];
	assign n_open    = !obs_rdata;
	assign sum       = {1'b0, base_q} + (COST_BITS+1)'(step_len(d_q));
	assign new_cost  = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
	assign n_improve = n_open && (!n_reach || (new_cost < n_cost));

	// ram port steering by state
	always_comb begin
		obs_we     = 1'b0;
		obs_waddr  = req_addr;
		obs_wdata  = req.blocked;
		obs_raddr  = n_addr;
		node_we    = 1'b0;
		node_waddr = clr_q;
		node_wdata = {1'b0, 1'b0, COST_MAX};
		node_raddr = req_addr;
		q_we       = 1'b0;
		q_waddr    = tail_q;
		q_wdata    = {ny[YW-1:0], nx[XW-1:0]};
		q_raddr    = head_q;
		case (st_q)
			ST_CLEAR: begin
				node_we   = 1'b1;
				obs_we    = clr_obs_q;
				obs_waddr = clr_q;
				obs_wdata = 1'b0;
			end
			ST_IDLE: begin
				obs_we = req_acc && (req.cmd == CMD_LOAD) && req_in_array;
			end
			ST_SEED: begin
				node_we    = 1'b1;
				node_waddr = cell_addr(gy_q, gx_q);
				node_wdata = {1'b1, 1'b1, {COST_BITS{1'b0}}};
				q_we       = 1'b1;
				q_waddr    = '0;
				q_wdata    = {gy_q, gx_q};
			end
			ST_POP_WAIT: begin
				node_raddr = cell_addr(q_rdata[QW-1:XW], q_rdata[XW-1:0]);
			end
			ST_BASE: begin
				// the dequeued cell leaves the queue
				node_we    = 1'b1;
				node_waddr = uaddr_q;
				node_wdata = {1'b0, node_rdata[NW-2:0]};
			end
			ST_NB_RD: begin
				node_raddr = n_addr;
			end
			ST_NB_WR: begin
				node_we    = n_improve;
				node_waddr = naddr_q;
				node_wdata = {1'b1, 1'b1, new_cost};
				q_we       = n_improve && !n_inq;
			end
			default: begin
			end
		endcase
	end

	godf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs_ram (
		.clk   (clk),
		.we    (obs_we),
		.waddr (obs_waddr),
		.wdata (obs_wdata),
		.raddr (obs_raddr),
		.rdata (obs_rdata)
	);

	godf_ram #(.WIDTH(NW), .DEPTH(CELLS)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	godf_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			clr_obs_q   <= 1'b1;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			d_q         <= '0;
			sopen_q     <= '0;
			rd_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
			gw_q        <= CFG_BITS'(64);
			gh_q        <= CFG_BITS'(64);
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_GRID_WIDTH) begin
					gw_q <= cfg_data;
				end else begin
					gh_q <= cfg_data;
				end
			end

			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			// read data lands in the cycle after the read transaction
			rd_s1 <= 1'b0;
			if (rd_s1) begin
				rsp_valid_q       <= 1'b1;
				rsp_q.reply_kind  <= REPLY_READ;
				rsp_q.path_cost   <= cost_out(node_rdata[COST_BITS-1:0]);
				rsp_q.reached     <= node_rdata[NW-2];
				rsp_q.status      <= STATUS_OK;
			end

			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_CELL) begin
						clr_q     <= '0;
						clr_obs_q <= 1'b0;
						st_q      <= clr_obs_q ? ST_IDLE : ST_SEED;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						case (req.cmd)
							CMD_BUILD: begin
								if (req_in_grid) begin
									gx_q <= XW'(req.x_coord);
									gy_q <= YW'(req.y_coord);
									st_q <= ST_CLEAR;
								end else begin
									rsp_valid_q <= 1'b1;
									rsp_q <= '{reply_kind: REPLY_BUILD, path_cost: 16'd0,
										reached: 1'b0, status: STATUS_ERR};
								end
							end
							CMD_READ: begin
								if (req_in_grid) begin
									rd_s1 <= 1'b1;
								end else begin
									rsp_valid_q <= 1'b1;
									rsp_q <= '{reply_kind: REPLY_READ, path_cost: 16'd0,
										reached: 1'b0, status: STATUS_ERR};
								end
							end
							default: begin
								// load is a ram write only, unused code is dropped
							end
						endcase
					end
				end
				ST_SEED: begin
					head_q <= '0;
					tail_q <= ptr_next('0);
					cnt_q  <= (AW+1)'(1);
					st_q   <= ST_POP_RD;
				end
				ST_POP_RD: begin
					if (cnt_q == '0) begin
						st_q <= ST_DONE;
					end else begin
						head_q <= ptr_next(head_q);
						cnt_q  <= cnt_q - 1'b1;
						st_q   <= ST_POP_WAIT;
					end
				end
				ST_POP_WAIT: begin
					ux_q    <= q_rdata[XW-1:0];
					uy_q    <= q_rdata[QW-1:XW];
					uaddr_q <= cell_addr(q_rdata[QW-1:XW], q_rdata[XW-1:0]);
					st_q    <= ST_BASE;
				end
				ST_BASE: begin
					base_q  <= node_rdata[COST_BITS-1:0];
					d_q     <= '0;
					sopen_q <= '0;
					st_q    <= ST_NB_RD;
				end
				ST_NB_RD: begin
					if (n_eligible) begin
						naddr_q <= n_addr;
						st_q    <= ST_NB_WR;
					end else begin
						if (!d_q[2]) begin
							sopen_q[d_q[1:0]] <= 1'b0;
						end
						d_q  <= d_q + 1'b1;
						st_q <= (d_q == 3'd7) ? ST_POP_RD : ST_NB_RD;
					end
				end
				ST_NB_WR: begin
					if (!d_q[2]) begin
						sopen_q[d_q[1:0]] <= n_open;
					end
					if (n_improve && !n_inq) begin
						tail_q <= ptr_next(tail_q);
						cnt_q  <= cnt_q + 1'b1;
					end
					d_q  <= d_q + 1'b1;
					st_q <= (d_q == 3'd7) ? ST_POP_RD : ST_NB_RD;
				end
				ST_DONE: begin
					// reply slot is free: nothing else loads it during a build
					rsp_valid_q <= 1'b1;
					rsp_q <= '{reply_kind: REPLY_BUILD, path_cost: 16'd0,
						reached: 1'b0, status: STATUS_OK};
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hw/rtl/godf_ram.sv
// generic single write port, single read port ram with registered read
module godf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/godf_check.sv
// port-level checker for the octile distance field, bound to the top level
module godf_check
	import godf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a waiting reply is not withdrawn
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("reply dropped while stalled");

	// an error reply carries no cost and no reached flag
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_ERR) |-> (rsp.path_cost == 16'd0) && !rsp.reached)
		else $error("error reply with data");

	// a build reply carries no cost and no reached flag
	a_build_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.reply_kind == REPLY_BUILD) |-> (rsp.path_cost == 16'd0) && !rsp.reached)
		else $error("build reply with data");

	// a read or build transaction is followed by a reply or by a busy request side
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && ((req.cmd == CMD_READ) || (req.cmd == CMD_BUILD))
		|=> req_stall || rsp_valid)
		else $error("read or build left neither a reply nor a stall");

endmodule

bind grid_octile_distance_field godf_check u_godf_check (.*);

>>> test/tb_top.sv
// testbench for the octile distance field: obstacle loads, field builds and cost reads
`timescale 1ns / 100ps

module tb_top;
	import godf_pkg::*;

	localparam int GRID_SIDE   = 64;
	localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
	localparam int COST_CAP    = 65535;
	localparam int STALL_LIMIT = 1500000;   // cycles with no transaction before giving up
	localparam int QUIET_WAIT  = 16;        // covers the read path (node ram read, then the reply register) and a load

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	// block inputs, all known from time zero
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp;
	logic                cfg_we = 1'b0;
	logic                cfg_index = CFG_GRID_WIDTH;
	logic [CFG_BITS-1:0] cfg_data = '0;

	grid_octile_distance_field dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of the grid state
	int unsigned  grid_w = 64;
	int unsigned  grid_h = 64;
	bit           wall_map [GRID_CELLS];
	int unsigned  cell_cost [GRID_CELLS];
	bit           cell_reached [GRID_CELLS];
	bit           cell_queued [GRID_CELLS];
	int unsigned  relax_fifo [$];

	rsp_t         pending_replies [$];

	// run statistics
	int unsigned  mismatches = 0;
	int unsigned  loads_sent = 0;
	int unsigned  builds_sent = 0;
	int unsigned  reads_sent = 0;
	int unsigned  replies_seen = 0;
	int unsigned  idle_cycles = 0;

	// sender burst state
	int unsigned  burst_left = 0;

	// neighbor order: left, right, up, down, then the four diagonals
	const int step_x [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
	const int step_y [8] = '{0, 0, -1, 1, -1, 1, -1, 1};
	const int step_w [8] = '{10, 10, 10, 10, 14, 14, 14, 14};

	function automatic int unsigned used_w();
		return (grid_w > GRID_SIDE) ? GRID_SIDE : grid_w;
	endfunction

	function automatic int unsigned used_h();
		return (grid_h > GRID_SIDE) ? GRID_SIDE : grid_h;
	endfunction

	function automatic bit in_grid(int x, int y);
		return x >= 0 && y >= 0 && x < int'(used_w()) && y < int'(used_h());
	endfunction

	function automatic bit walkable(int x, int y);
		return in_grid(x, y) && !wall_map[y * GRID_SIDE + x];
	endfunction

	// spfa relaxation from the goal over 8 neighbors, corners not cut
	function automatic void relax_from_goal(int gx, int gy);
		int unsigned u, v, base, ncost;
		int ux, uy, nx, ny;
		for (int i = 0; i < GRID_CELLS; i++) begin
			cell_cost[i] = COST_CAP;
			cell_reached[i] = 1'b0;
			cell_queued[i] = 1'b0;
		end
		relax_fifo.delete();
		u = gy * GRID_SIDE + gx;
		cell_cost[u] = 0;
		cell_reached[u] = 1'b1;
		cell_queued[u] = 1'b1;
		relax_fifo.push_back(u);
		while (relax_fifo.size() != 0) begin
			u = relax_fifo.pop_front();
			ux = u % GRID_SIDE;
			uy = u / GRID_SIDE;
			base = cell_cost[u];
			cell_queued[u] = 1'b0;
			for (int d = 0; d < 8; d++) begin
				nx = ux + step_x[d];
				ny = uy + step_y[d];
				if (!walkable(nx, ny))
					continue;
				if (d >= 4 && !(walkable(nx, uy) && walkable(ux, ny)))
					continue;
				v = ny * GRID_SIDE + nx;
				ncost = base + step_w[d];
				if (ncost > COST_CAP)
					ncost = COST_CAP;
				if (!cell_reached[v] || ncost < cell_cost[v]) begin
					cell_cost[v] = ncost;
					cell_reached[v] = 1'b1;
					if (!cell_queued[v]) begin
						cell_queued[v] = 1'b1;
						relax_fifo.push_back(v);
					end
				end
			end
		end
	endfunction

	// apply one accepted request to the shadow state, queue the reply it causes
	function automatic void apply_request(req_t r);
		rsp_t e;
		int x, y;
		x = r.x_coord;
		y = r.y_coord;
		e = '0;
		case (r.cmd)
			CMD_LOAD: begin
				// 6-bit coordinates always land in the stored array
				wall_map[y * GRID_SIDE + x] = r.blocked;
			end
			CMD_BUILD: begin
				e.reply_kind = REPLY_BUILD;
				if (!in_grid(x, y)) begin
					e.status = STATUS_ERR;
				end else begin
					relax_from_goal(x, y);
					e.status = STATUS_OK;
				end
				pending_replies.push_back(e);
			end
			CMD_READ: begin
				e.reply_kind = REPLY_READ;
				if (!in_grid(x, y)) begin
					e.status = STATUS_ERR;
				end else begin
					e.path_cost = 16'(cell_cost[y * GRID_SIDE + x]);
					e.reached = cell_reached[y * GRID_SIDE + x];
					e.status = STATUS_OK;
				end
				pending_replies.push_back(e);
			end
			default: ;   // unknown command, no reply
		endcase
	endfunction

	// send one transaction; the sender runs in bursts with random gaps between them
	task automatic send_cmd(logic [1:0] cmd, int x, int y, bit blk);
		req_t r;
		r.cmd = cmd;
		r.x_coord = x[5:0];
		r.y_coord = y[5:0];
		r.blocked = blk;
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		apply_request(r);
		case (cmd)
			CMD_LOAD:  loads_sent++;
			CMD_BUILD: builds_sent++;
			CMD_READ:  reads_sent++;
			default: ;
		endcase
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// long bursts half the time so back-to-back streams happen too
			burst_left = ($urandom_range(0, 1) != 0) ? $urandom_range(10, 40)
			                                         : $urandom_range(0, 4);
		end else begin
			burst_left--;
		end
	endtask

	// hold off until every reply is back and the block has gone quiet
	task automatic drain_replies();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (QUIET_WAIT) @(posedge clk);
	endtask

	// write both size registers while the block is idle
	task automatic set_grid_size(int unsigned w, int unsigned h);
		drain_replies();
		cfg_we <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_data <= w[CFG_BITS-1:0];
		@(posedge clk);
		cfg_index <= CFG_GRID_HEIGHT;
		cfg_data <= h[CFG_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_w = w & 32'h7f;
		grid_h = h & 32'h7f;
	endtask

	// open 64x64 grid straight after reset, goal in the far corner
	task automatic test_full_open_grid();
		send_cmd(CMD_READ, 0, 0, 1'b0);        // never built: unreached
		send_cmd(CMD_BUILD, 63, 63, 1'b0);
		send_cmd(CMD_READ, 0, 0, 1'b0);
		send_cmd(CMD_READ, 63, 0, 1'b0);
		send_cmd(CMD_READ, 0, 63, 1'b0);
		send_cmd(CMD_READ, 63, 63, 1'b0);
		send_cmd(CMD_READ, 42, 21, 1'b0);
		drain_replies();                      // sender waits out every reply
	endtask

	// tiny grid: corner cutting, goal on a wall, outside coordinates, unknown command
	task automatic test_small_grid_cases();
		set_grid_size(4, 3);
		send_cmd(CMD_LOAD, 1, 0, 1'b1);        // blocks the diagonal from (0,0) to (1,1)
		send_cmd(CMD_LOAD, 2, 2, 1'b1);        // goal will sit on this wall
		send_cmd(CMD_LOAD, 40, 50, 1'b1);      // outside the grid but stored
		send_cmd(CMD_BUILD, 2, 2, 1'b0);
		send_cmd(CMD_READ, 0, 0, 1'b0);
		send_cmd(CMD_READ, 1, 0, 1'b0);        // wall: stays unreached
		send_cmd(CMD_READ, 2, 2, 1'b0);
		send_cmd(CMD_READ, 3, 0, 1'b0);
		send_cmd(CMD_READ, 4, 1, 1'b0);        // outside
		send_cmd(2'd3, 63, 63, 1'b1);          // unknown command
		send_cmd(CMD_BUILD, 4, 0, 1'b0);       // goal outside: error, field kept
		send_cmd(CMD_READ, 0, 1, 1'b0);
		send_cmd(CMD_LOAD, 1, 0, 1'b0);
	endtask

	// size registers at zero and beyond the stored array
	task automatic test_size_extremes();
		set_grid_size(0, 127);
		send_cmd(CMD_READ, 0, 0, 1'b0);
		send_cmd(CMD_BUILD, 0, 0, 1'b0);
		set_grid_size(127, 0);
		send_cmd(CMD_READ, 5, 0, 1'b0);
		set_grid_size(127, 2);                 // width taken as 64
		send_cmd(CMD_BUILD, 63, 1, 1'b0);
		send_cmd(CMD_READ, 0, 0, 1'b0);
		send_cmd(CMD_READ, 40, 50, 1'b0);
	endtask

	// random cell: mostly inside the grid, sometimes anywhere in 6 bits
	task automatic pick_cell(output int x, output int y, input int inside_pct);
		if (used_w() != 0 && used_h() != 0 && $urandom_range(0, 99) < inside_pct) begin
			x = $urandom_range(0, used_w() - 1);
			y = $urandom_range(0, used_h() - 1);
		end else begin
			x = $urandom_range(0, 63);
			y = $urandom_range(0, 63);
		end
	endtask

	// rounds of: grid size, obstacle loads, a build, reads with some noise mixed in
	task automatic test_random_rounds(int unsigned target);
		int unsigned sent, w, h, n;
		int x, y;
		sent = 0;
		while (sent < target) begin
			case ($urandom_range(0, 9))
				0: begin w = $urandom_range(13, 127); h = $urandom_range(0, 3); end
				1: begin w = $urandom_range(0, 3); h = $urandom_range(13, 127); end
				default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12); end
			endcase
			set_grid_size(w, h);
			n = $urandom_range(3, 14);
			repeat (n) begin
				pick_cell(x, y, 85);
				send_cmd(CMD_LOAD, x, y, $urandom_range(0, 99) < 35);
				sent++;
			end
			pick_cell(x, y, 92);
			send_cmd(CMD_BUILD, x, y, $urandom_range(0, 1));
			sent++;
			n = $urandom_range(10, 30);
			repeat (n) begin
				pick_cell(x, y, 88);
				case ($urandom_range(0, 19))
					0: send_cmd(CMD_LOAD, x, y, $urandom_range(0, 1));
					1: send_cmd(CMD_BUILD, x, y, $urandom_range(0, 1));
					2: send_cmd(2'd3, x, y, $urandom_range(0, 1));
					default: send_cmd(CMD_READ, x, y, $urandom_range(0, 1));
				endcase
				sent++;
			end
		end
	endtask

	// reply stall: quiet stretches, light and heavy random stalling, and a regular pattern
	int unsigned stall_mode = 0;
	int unsigned stall_count = 0;
	always @(posedge clk) begin
		stall_count <= stall_count + 1;
		if (stall_count % 97 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 4) != 0);
			default: rsp_stall <= stall_count[2];
		endcase
	end

	// reply checker: every accepted reply against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			replies_seen++;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply: kind %0d cost %0d reached %0d status %0d",
					         rsp.reply_kind, rsp.path_cost, rsp.reached, rsp.status);
			end else begin
				rsp_t e;
				e = pending_replies.pop_front();
				if (rsp.reply_kind !== e.reply_kind || rsp.path_cost !== e.path_cost ||
				    rsp.reached !== e.reached || rsp.status !== e.status) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("reply mismatch: expected kind %0d cost %0d reached %0d status %0d",
						         e.reply_kind, e.path_cost, e.reached, e.status);
						$display("                got kind %0d cost %0d reached %0d status %0d",
						         rsp.reply_kind, rsp.path_cost, rsp.reached, rsp.status);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		// every cell starts unreached
		foreach (cell_cost[i])
			cell_cost[i] = COST_CAP;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_open_grid();
		test_small_grid_cases();
		test_size_extremes();
		test_random_rounds(1750);
		drain_replies();
		repeat (40) @(posedge clk);
		if (pending_replies.size() != 0)
			mismatches += pending_replies.size();
		$display("covered %0d loads, %0d builds and %0d reads; %0d replies checked",
		         loads_sent, builds_sent, reads_sent, replies_seen);
		$display("grid sizes from zero to beyond the array, %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/godf_pkg.sv
hw/rtl/godf_ram.sv
hw/rtl/grid_octile_distance_field.sv
hw/rtl/godf_check.sv
test/tb_top.sv
